// ===== hw/rtl/slrf_pkg.sv =====
// shared types and constants for the least-squares line fit block
`default_nettype none
package slrf_pkg;

	// item opcodes
	typedef enum logic [1:0] {
		OP_FIT     = 2'd0,
		OP_SCORE   = 2'd1,
		OP_PREDICT = 2'd2
	} opcode_t;

	// result kinds
	localparam logic [1:0] RK_FIT  = 2'd0;
	localparam logic [1:0] RK_MSE  = 2'd1;
	localparam logic [1:0] RK_PRED = 2'd2;

	// fixed datapath widths
	localparam int LIN_W     = 49;   // slope*x + intercept*2^8, scale 2^16
	localparam int MUL_P_W   = 112;  // shift-add multiplier product
	localparam int MUL_B_W   = 48;   // multiplier bits consumed, one per cycle
	localparam int MUL_CNT_W = 6;
	localparam int DIV_N_W   = 96;   // divider numerator magnitude
	localparam int DIV_D_W   = 64;   // divider denominator magnitude
	localparam int DIV_CNT_W = 7;
	localparam int SQ_LSB    = 32;   // squared error scaled down to an unsigned 64-bit integer (Q64.0)
	localparam int MSE_W     = 48;

	localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// product selection for the shared multiplier
	typedef enum logic [2:0] {
		MS_NXX,
		MS_SXSX,
		MS_NXY,
		MS_SXSY,
		MS_XXSY,
		MS_SXXY,
		MS_DD
	} mul_sel_t;

	// quotient selection for the shared divider
	typedef enum logic [1:0] {
		DS_WEIGHT,
		DS_BIAS,
		DS_MEAN,
		DS_MSE
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_POST,
		S_MGO,
		S_MWAIT,
		S_MWB,
		S_DGO,
		S_DWAIT,
		S_DWB,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       item_load;
		logic       acc_fit;
		logic       cnt_inc;
		logic       lin_calc;
		logic       d_calc;
		logic       mul_start;
		logic       mul_wb;
		mul_sel_t   mul_sel;
		logic       div_start;
		logic       div_wb;
		div_sel_t   div_sel;
		logic       emit;
		logic [1:0] emit_kind;
		logic       clear;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic       cnt_ok;
		logic       mul_busy;
		logic       div_busy;
		logic       den_zero;
		logic       out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/slrf_in_if.sv =====
// input item channel
`default_nettype none
interface slrf_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [15:0] sample_x;
	logic signed [15:0] sample_y;
	logic               last;

	modport source(output valid, opcode, sample_x, sample_y, last, input ready);
	modport sink(input valid, opcode, sample_x, sample_y, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/slrf_out_if.sv =====
// result item channel
`default_nettype none
interface slrf_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic signed [31:0] weight;
	logic signed [31:0] bias;
	logic [47:0]        mean_sq_error;
	logic signed [31:0] prediction;
	logic               degenerate;

	modport source(output valid, result_kind, weight, bias, mean_sq_error, prediction,
		degenerate, input ready);
	modport sink(input valid, result_kind, weight, bias, mean_sq_error, prediction,
		degenerate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/slrf_ctrl.sv =====
// sequencer for item handling, multiply and divide bursts
`default_nettype none
module slrf_ctrl import slrf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t   state_q, state_d;
	mul_sel_t msel_q, msel_d;
	div_sel_t dsel_q, dsel_d;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			msel_q  <= MS_NXX;
			dsel_q  <= DS_WEIGHT;
		end else begin
			state_q <= state_d;
			msel_q  <= msel_d;
			dsel_q  <= dsel_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		msel_d  = msel_q;
		dsel_d  = dsel_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_EXEC;
			S_EXEC: begin
				case (st.op) inside
					OP_FIT: begin
						if (st.last) begin
							msel_d  = MS_NXX;
							state_d = S_MGO;
						end else begin
							state_d = S_IDLE;
						end
					end
					OP_SCORE, OP_PREDICT: state_d = S_POST;
					default: state_d = S_IDLE;
				endcase
			end
			S_POST: begin
				if (st.op == OP_PREDICT) begin
					state_d = S_EMIT;
				end else if (st.cnt_ok) begin
					msel_d  = MS_DD;
					state_d = S_MGO;
				end else if (st.last) begin
					dsel_d  = DS_MSE;
					state_d = S_DGO;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_MGO:   state_d = S_MWAIT;
			S_MWAIT: if (!st.mul_busy) state_d = S_MWB;
			S_MWB: begin
				state_d = S_MGO;
				unique case (msel_q)
					MS_NXX:  msel_d = MS_SXSX;
					MS_SXSX: msel_d = MS_NXY;
					MS_NXY:  msel_d = MS_SXSY;
					MS_SXSY: msel_d = MS_XXSY;
					MS_XXSY: msel_d = MS_SXXY;
					MS_SXXY: begin
						dsel_d  = st.den_zero ? DS_MEAN : DS_WEIGHT;
						state_d = S_DGO;
					end
					MS_DD: begin
						if (st.last) begin
							dsel_d  = DS_MSE;
							state_d = S_DGO;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_DGO:   state_d = S_DWAIT;
			S_DWAIT: if (!st.div_busy) state_d = S_DWB;
			S_DWB: begin
				if (dsel_q == DS_WEIGHT) begin
					dsel_d  = DS_BIAS;
					state_d = S_DGO;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_EMIT:  if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		cmd.mul_sel = msel_q;
		cmd.div_sel = dsel_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				cmd.item_load = in_valid;
			end
			S_EXEC: begin
				cmd.acc_fit  = (st.op == OP_FIT) && st.cnt_ok;
				cmd.lin_calc = (st.op == OP_SCORE) || (st.op == OP_PREDICT);
			end
			S_POST: begin
				cmd.d_calc  = (st.op == OP_SCORE);
				cmd.cnt_inc = (st.op == OP_SCORE) && st.cnt_ok;
			end
			S_MGO: cmd.mul_start = 1'b1;
			S_MWB: cmd.mul_wb    = 1'b1;
			S_DGO: cmd.div_start = 1'b1;
			S_DWB: cmd.div_wb    = 1'b1;
			S_EMIT: begin
				cmd.emit  = st.out_free;
				cmd.clear = st.out_free && st.last && (st.op != OP_PREDICT);
				case (st.op) inside
					OP_FIT:   cmd.emit_kind = RK_FIT;
					OP_SCORE: cmd.emit_kind = RK_MSE;
					default:  cmd.emit_kind = RK_PRED;
				endcase
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/slrf_dp.sv =====
// accumulators, model, shift-add multiplier, restoring divider and result register
`default_nettype none
module slrf_dp import slrf_pkg::*; #(
	parameter int MAX_SAMPLES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output status_t            st,
	input  logic [1:0]         in_opcode,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic               in_last,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [1:0]         out_kind,
	output logic signed [31:0] out_weight,
	output logic signed [31:0] out_bias,
	output logic [47:0]        out_mse,
	output logic signed [31:0] out_pred,
	output logic               out_degenerate
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SX_W  = 16 + CNT_W;
	localparam int SXY_W = 32 + CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

	// latched item
	logic [1:0]         op_q;
	logic signed [15:0] x_q, y_q;
	logic               last_q;

	// pass accumulators and model
	logic signed [SX_W-1:0]  acc_x_q, acc_y_q;
	logic signed [SXY_W-1:0] acc_xy_q, acc_xx_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [63:0]             acc_sq_q;
	logic signed [31:0]      slope_q, icpt_q;
	logic signed [LIN_W-1:0] lin_q, d_q;

	// multiplier
	logic signed [MUL_P_W-1:0] m_a_q, m_acc_q, t_q, den_q, wn_q, bn_q;
	logic [MUL_B_W-1:0]        m_b_q;
	logic [MUL_CNT_W-1:0]      m_cnt_q;
	logic                      m_busy_q;

	// divider
	logic [DIV_N_W-1:0]   dv_num_q, dv_quo_q;
	logic [DIV_D_W-1:0]   dv_den_q;
	logic [DIV_D_W-1:0]   dv_rem_q;
	logic                 dv_neg_q;
	logic [DIV_CNT_W-1:0] dv_cnt_q;
	logic                 dv_busy_q;
	logic [MSE_W-1:0]     mse_res_q;

	// result register
	logic               out_valid_q;
	logic [1:0]         out_kind_q;
	logic signed [31:0] out_weight_q, out_bias_q, out_pred_q;
	logic [47:0]        out_mse_q;
	logic               out_deg_q;

	logic cnt_ok, den_zero, out_free;
	assign cnt_ok   = cnt_q < CNT_MAX;
	assign den_zero = (den_q == '0);
	assign out_free = !out_valid_q || out_ready;

	assign st.op       = op_q;
	assign st.last     = last_q;
	assign st.cnt_ok   = cnt_ok;
	assign st.mul_busy = m_busy_q;
	assign st.div_busy = dv_busy_q;
	assign st.den_zero = den_zero;
	assign st.out_free = out_free;

	// per-sample products and model evaluation
	logic signed [31:0]      xy_prod, xx_prod;
	logic signed [47:0]      sx_prod;
	logic signed [LIN_W-1:0] lin_new, d_new;
	assign xy_prod = x_q * y_q;
	assign xx_prod = x_q * x_q;
	assign sx_prod = slope_q * x_q;
	assign lin_new = LIN_W'(sx_prod) + (LIN_W'(icpt_q) <<< 8);
	assign d_new   = lin_q - (LIN_W'(y_q) <<< 16);

	// multiplier operand selection
	logic signed [MUL_P_W-1:0] a_sel, a_eff;
	logic signed [LIN_W-1:0]   b_sel, b_mag, d_mag, n_val;
	logic                      b_neg;
	assign d_mag = d_q[LIN_W-1] ? -d_q : d_q;
	assign n_val = LIN_W'({1'b0, cnt_q});
	always_comb begin
		case (cmd.mul_sel)
			MS_NXX:  begin a_sel = MUL_P_W'(acc_xx_q); b_sel = n_val;           end
			MS_SXSX: begin a_sel = MUL_P_W'(acc_x_q);  b_sel = LIN_W'(acc_x_q); end
			MS_NXY:  begin a_sel = MUL_P_W'(acc_xy_q); b_sel = n_val;           end
			MS_SXSY: begin a_sel = MUL_P_W'(acc_y_q);  b_sel = LIN_W'(acc_x_q); end
			MS_XXSY: begin a_sel = MUL_P_W'(acc_xx_q); b_sel = LIN_W'(acc_y_q); end
			MS_SXXY: begin a_sel = MUL_P_W'(acc_xy_q); b_sel = LIN_W'(acc_x_q); end
			default: begin a_sel = MUL_P_W'(d_mag);    b_sel = d_mag;           end
		endcase
	end
	assign b_neg = b_sel[LIN_W-1];
	assign b_mag = b_neg ? -b_sel : b_sel;
	assign a_eff = b_neg ? -a_sel : a_sel;

	// saturating squared-error add
	logic [64:0] sq_sum;
	assign sq_sum = {1'b0, acc_sq_q} + {1'b0, m_acc_q[SQ_LSB+63:SQ_LSB]};

	// divider operand selection
	logic signed [MUL_P_W-1:0] num_sel;
	logic [MUL_P_W-1:0]        num_mag, num_sh;
	logic                      num_neg;
	always_comb begin
		case (cmd.div_sel)
			DS_WEIGHT: num_sel = wn_q;
			DS_BIAS:   num_sel = bn_q;
			DS_MEAN:   num_sel = MUL_P_W'(acc_y_q);
			default:   num_sel = MUL_P_W'({1'b0, acc_sq_q});
		endcase
	end
	assign num_neg = num_sel[MUL_P_W-1];
	assign num_mag = num_neg ? -num_sel : num_sel;
	always_comb begin
		case (cmd.div_sel)
			DS_WEIGHT:        num_sh = num_mag << 16;
			DS_BIAS, DS_MEAN: num_sh = num_mag << 8;
			default:          num_sh = num_mag;
		endcase
	end

	// divider step
	logic [DIV_D_W:0] rem_sh, rem_sub;
	logic             q_bit;
	assign rem_sh  = {dv_rem_q, dv_num_q[DIV_N_W-1]};
	assign rem_sub = rem_sh - {1'b0, dv_den_q};
	assign q_bit   = !rem_sub[DIV_D_W];

	// quotient saturation
	logic               q_pos_ovf, q_neg_ovf;
	logic signed [31:0] q_sat;
	assign q_pos_ovf = (dv_quo_q[DIV_N_W-1:31] != '0);
	assign q_neg_ovf = (dv_quo_q[DIV_N_W-1:32] != '0) ||
		(dv_quo_q[31] && (dv_quo_q[30:0] != '0));
	always_comb begin
		if (dv_neg_q) q_sat = q_neg_ovf ? S32_MIN : -signed'(dv_quo_q[31:0]);
		else          q_sat = q_pos_ovf ? S32_MAX : signed'(dv_quo_q[31:0]);
	end

	// prediction floor and saturation
	logic signed [LIN_W-1:0] lin_fl;
	logic signed [31:0]      pred_sat;
	assign lin_fl = lin_q >>> 8;
	always_comb begin
		if ((lin_fl[LIN_W-1:31] == '0) || (lin_fl[LIN_W-1:31] == '1))
			pred_sat = lin_fl[31:0];
		else
			pred_sat = lin_fl[LIN_W-1] ? S32_MIN : S32_MAX;
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q   <= in_opcode;
			x_q    <= in_x;
			y_q    <= in_y;
			last_q <= in_last;
		end
		if (cmd.lin_calc) lin_q <= lin_new;
		if (cmd.d_calc)   d_q   <= d_new;
	end

	// accumulators and model
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_xy_q <= '0;
			acc_xx_q <= '0;
			cnt_q    <= '0;
			acc_sq_q <= '0;
			slope_q  <= Q_ONE;
			icpt_q   <= '0;
		end else begin
			if (cmd.clear) begin
				acc_x_q  <= '0;
				acc_y_q  <= '0;
				acc_xy_q <= '0;
				acc_xx_q <= '0;
				cnt_q    <= '0;
				acc_sq_q <= '0;
			end else begin
				if (cmd.acc_fit) begin
					acc_x_q  <= acc_x_q + SX_W'(x_q);
					acc_y_q  <= acc_y_q + SX_W'(y_q);
					acc_xy_q <= acc_xy_q + SXY_W'(xy_prod);
					acc_xx_q <= acc_xx_q + SXY_W'(xx_prod);
				end
				if (cmd.acc_fit || cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
				if (cmd.mul_wb && cmd.mul_sel == MS_DD)
					acc_sq_q <= sq_sum[64] ? '1 : sq_sum[63:0];
			end
			if (cmd.div_wb) begin
				case (cmd.div_sel)
					DS_WEIGHT: slope_q <= q_sat;
					DS_BIAS:   icpt_q  <= q_sat;
					DS_MEAN: begin
						slope_q <= '0;
						icpt_q  <= q_sat;
					end
					default: ;
				endcase
			end
		end
	end

	// shift-add multiplier, one bit of b per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_busy_q <= 1'b0;
			m_cnt_q  <= '0;
		end else if (cmd.mul_start) begin
			m_busy_q <= 1'b1;
			m_cnt_q  <= '0;
		end else if (m_busy_q) begin
			m_cnt_q <= m_cnt_q + 1'b1;
			if (m_cnt_q == MUL_CNT_W'(MUL_B_W - 1)) m_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			m_a_q   <= a_eff;
			m_b_q   <= b_mag[MUL_B_W-1:0];
			m_acc_q <= '0;
		end else if (m_busy_q) begin
			if (m_b_q[0]) m_acc_q <= m_acc_q + m_a_q;
			m_a_q <= m_a_q <<< 1;
			m_b_q <= m_b_q >> 1;
		end
		// product pairs into numerators and denominator
		if (cmd.mul_wb) begin
			case (cmd.mul_sel)
				MS_NXX, MS_NXY, MS_XXSY: t_q <= m_acc_q;
				MS_SXSX: den_q <= t_q - m_acc_q;
				MS_SXSY: wn_q  <= t_q - m_acc_q;
				MS_SXXY: bn_q  <= t_q - m_acc_q;
				default: ;
			endcase
		end
	end

	// restoring divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_cnt_q  <= '0;
		end else if (cmd.div_start) begin
			dv_busy_q <= 1'b1;
			dv_cnt_q  <= '0;
		end else if (dv_busy_q) begin
			dv_cnt_q <= dv_cnt_q + 1'b1;
			if (dv_cnt_q == DIV_CNT_W'(DIV_N_W - 1)) dv_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dv_num_q <= num_sh[DIV_N_W-1:0];
			dv_neg_q <= num_neg;
			dv_rem_q <= '0;
			dv_quo_q <= '0;
			if (cmd.div_sel == DS_WEIGHT || cmd.div_sel == DS_BIAS)
				dv_den_q <= den_q[DIV_D_W-1:0];
			else
				dv_den_q <= DIV_D_W'(cnt_q);
		end else if (dv_busy_q) begin
			dv_num_q <= dv_num_q << 1;
			dv_rem_q <= q_bit ? rem_sub[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
			dv_quo_q <= {dv_quo_q[DIV_N_W-2:0], q_bit};
		end
		if (cmd.div_wb && cmd.div_sel == DS_MSE)
			mse_res_q <= (dv_quo_q[DIV_N_W-1:MSE_W] != '0) ? '1 : dv_quo_q[MSE_W-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= cmd.emit_kind;
			out_weight_q <= (cmd.emit_kind == RK_FIT)  ? slope_q   : '0;
			out_bias_q   <= (cmd.emit_kind == RK_FIT)  ? icpt_q    : '0;
			out_deg_q    <= (cmd.emit_kind == RK_FIT)  ? den_zero  : 1'b0;
			out_mse_q    <= (cmd.emit_kind == RK_MSE)  ? mse_res_q : '0;
			out_pred_q   <= (cmd.emit_kind == RK_PRED) ? pred_sat  : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_weight     = out_weight_q;
	assign out_bias       = out_bias_q;
	assign out_mse        = out_mse_q;
	assign out_pred       = out_pred_q;
	assign out_degenerate = out_deg_q;

	// checks
	a_mul_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !m_busy_q && !dv_busy_q)
		else $error("multiplier restarted while busy");
	a_div_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_wb |-> !dv_busy_q && !cmd.div_start)
		else $error("divider result taken while busy");
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q && out_kind_q == $past(cmd.emit_kind))
		else $error("emitted result not presented");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_fit || cmd.cnt_inc) |=> cnt_q <= CNT_MAX && cnt_q != '0)
		else $error("sample count past its limit");

endmodule
`default_nettype wire

// ===== hw/rtl/simple_linear_regression_fit.sv =====
// least-squares line fit top level: fit, score and predict over a valid/ready channel
// fit sample: accumulated in the execute state; predict: evaluated, then loaded into the result register
// score sample: squared error formed by the 48-step shift-add multiplier
// closing fit: six 48-step products and two 96-step divisions (one mean division if degenerate)
// closing score: adds the 96-step mean division
// reset (arst_n low, asynchronous) clears all sums and the count, sets slope 1.0, intercept 0
`default_nettype none
module simple_linear_regression_fit import slrf_pkg::*; #(
	parameter int MAX_SAMPLES = 256
) (
	input logic        clk,
	input logic        arst_n,
	slrf_in_if.sink    in_ch,
	slrf_out_if.source out_ch
);

	cmd_t    cmd;
	status_t st;

	slrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	slrf_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_opcode      (in_ch.opcode),
		.in_x           (in_ch.sample_x),
		.in_y           (in_ch.sample_y),
		.in_last        (in_ch.last),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.out_kind       (out_ch.result_kind),
		.out_weight     (out_ch.weight),
		.out_bias       (out_ch.bias),
		.out_mse        (out_ch.mean_sq_error),
		.out_pred       (out_ch.prediction),
		.out_degenerate (out_ch.degenerate)
	);

endmodule
`default_nettype wire
